// ----- hdl/hcbp_pkg.sv -----
// Package for the code bit packer: request codes, widths and the command
// type passed from the table lookup front to the bit packing back end.
// No dependencies.
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_LIMIT   = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    // Bit window of the packer: up to seven pending bits plus one code.
    localparam int WIN_W = CODE_LIMIT + 8;
    localparam int CNT_W = $clog2(WIN_W + 1);

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/hcbp_if.sv -----
// Valid/ready channel interfaces for the request and byte streams.
// Depends on hcbp_pkg for field widths.
interface hcbp_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [hcbp_pkg::SYM_W-1:0]   symbol;
    logic [hcbp_pkg::CODE_W-1:0]  code_bits;
    logic [hcbp_pkg::LEN_W-1:0]   code_length;

    modport source (output valid, output req_type, output symbol, output code_bits,
                    output code_length, input ready);
    modport sink (input valid, input req_type, input symbol, input code_bits,
                  input code_length, output ready);
endinterface

interface hcbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ----- hdl/huffman_code_bit_packer.sv -----
// Top level of the code bit packer: lookup front, command queue, packer back.
// Depends on hcbp_pkg, hcbp_if, hcbp_front, hcbp_queue and hcbp_back.
//
// Usage:
//   i_in carries requests: req_type load writes a table entry (symbol,
//   code_bits, code_length), encode looks up symbol and packs its code,
//   flush appends a 1 terminator, pads to a byte and empties the buffer.
//   o_out carries packed bytes, first code bit in bit 7, with last set on
//   the final byte produced by each request.
//   Path: an encode or flush transfer reaches o_out through the table read
//   register, a queue write and the output register load.
//   Throughput: one request per cycle while the queue has room; the packer
//   emits one byte per cycle while the receiver is ready, so a request
//   yielding k bytes occupies it until all k are emitted, and the
//   four-entry queue absorbs the difference before i_in.ready drops.
//   A load can be followed by an encode of the same symbol in the next cycle.
//   Reset: the table reads as empty at once through per-entry valid bits,
//   the bit buffer and queue are cleared; no clearing pass is needed.
//   When the receiver stalls, the output byte holds, the packer and then
//   the queue fill, and i_in.ready deasserts; nothing is dropped.
module huffman_code_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    hcbp_out_if.source  o_out
);
    hcbp_pkg::t_cmd       push_cmd;
    hcbp_pkg::t_cmd       pop_cmd;
    hcbp_pkg::t_q_status  q_status;
    logic                 push;
    logic                 pop;

    hcbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    hcbp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (pop_cmd),
        .o_status (q_status)
    );

    hcbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (pop_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ----- hdl/hcbp_front.sv -----
// Front end: accepts requests, keeps the 256-entry code table and looks up
// encode symbols. Depends on hcbp_pkg and hcbp_in_if.
module hcbp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hcbp_in_if.sink              i_in,
    input  hcbp_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output hcbp_pkg::t_cmd       o_cmd
);
    localparam int ENT_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    logic [ENT_W-1:0]             r_mem [256];
    logic [255:0]                 r_vld;
    logic [ENT_W-1:0]             r_rd_data;
    logic                         r_rd_hit;
    logic                         r_s1_valid;
    logic                         r_s1_flush;

    logic                         accept;
    logic                         is_load;
    logic                         is_enc;
    logic                         is_flush;
    logic [hcbp_pkg::LEN_W-1:0]   len_sat;
    logic [hcbp_pkg::CODE_W-1:0]  code_mask;

    always_comb begin
        i_in.ready = !r_s1_valid || !i_q_status.full;
        accept     = i_in.valid && i_in.ready;
        is_load    = i_in.req_type == hcbp_pkg::REQ_LOAD;
        is_enc     = i_in.req_type == hcbp_pkg::REQ_ENCODE;
        is_flush   = i_in.req_type == hcbp_pkg::REQ_FLUSH;
        o_push     = r_s1_valid && !i_q_status.full;

        // Saturate the length, then drop code bits above it.
        if (i_in.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LIMIT)) begin
            len_sat = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LIMIT);
        end else begin
            len_sat = i_in.code_length;
        end
        if (len_sat >= hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W)) begin
            code_mask = '1;
        end else begin
            code_mask = ~({hcbp_pkg::CODE_W{1'b1}} << len_sat);
        end

        o_cmd.flush = r_s1_flush;
        if (r_rd_hit && !r_s1_flush) begin
            o_cmd.code = r_rd_data[ENT_W-1 -: hcbp_pkg::CODE_W];
            o_cmd.len  = r_rd_data[hcbp_pkg::LEN_W-1:0];
        end else begin
            o_cmd.code = '0;
            o_cmd.len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (accept && (is_enc || is_flush)) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (accept && is_load) begin
                r_vld[i_in.symbol] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_mem[i_in.symbol] <= {i_in.code_bits & code_mask, len_sat};
        end
        if (accept && (is_enc || is_flush)) begin
            r_rd_data  <= r_mem[i_in.symbol];
            r_rd_hit   <= r_vld[i_in.symbol];
            r_s1_flush <= is_flush;
        end
    end

    // A looked-up command waits in place while the queue is full.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && i_q_status.full) |=> (r_s1_valid && $stable(r_s1_flush)))
        else $error("front stage dropped a command while the queue was full");

endmodule

// ----- hdl/hcbp_queue.sv -----
// Short command queue between the lookup front and the packing back end.
// Depends on hcbp_pkg.
module hcbp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hcbp_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output hcbp_pkg::t_cmd       o_cmd,
    output hcbp_pkg::t_q_status  o_status
);
    hcbp_pkg::t_cmd                 r_mem [hcbp_pkg::Q_DEPTH];
    logic [hcbp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [hcbp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [hcbp_pkg::QCNT_W-1:0]    r_count;

    always_comb begin
        o_status.full  = r_count == hcbp_pkg::QCNT_W'(hcbp_pkg::Q_DEPTH);
        o_status.empty = r_count == '0;
        o_cmd          = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from an empty command queue");

endmodule

// ----- hdl/hcbp_back.sv -----
// Back end: MSB-first bit window that merges codes, emits completed bytes
// one per cycle into the output register while it is free, and handles the terminator flush.
// Depends on hcbp_pkg and hcbp_out_if.
module hcbp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hcbp_pkg::t_cmd       i_cmd,
    input  hcbp_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    hcbp_out_if.source           o_out
);
    localparam int WIN_W = hcbp_pkg::WIN_W;
    localparam int CNT_W = hcbp_pkg::CNT_W;

    // Pending bits sit left aligned in the window; bits below the count are zero.
    logic [WIN_W-1:0]  r_win;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ov;
    logic [7:0]        r_ob;
    logic              r_ol;

    logic [WIN_W-1:0]  n_win;
    logic [CNT_W-1:0]  n_cnt;
    logic [WIN_W-1:0]  code_al;
    logic [WIN_W-1:0]  top_one;
    logic [WIN_W-1:0]  m_win;
    logic [CNT_W-1:0]  m_cnt;
    logic              out_free;
    logic              emit;
    logic [7:0]        e_byte;
    logic              e_last;

    always_comb begin
        out_free = !r_ov || o_out.ready;
        code_al  = (WIN_W'(i_cmd.code) << (CNT_W'(WIN_W) - CNT_W'(i_cmd.len))) >> r_cnt;
        top_one  = {1'b1, {(WIN_W-1){1'b0}}} >> r_cnt;
        if (i_cmd.flush) begin
            m_win = r_win | top_one;
            m_cnt = CNT_W'(8);
        end else begin
            m_win = r_win | code_al;
            m_cnt = r_cnt + CNT_W'(i_cmd.len);
        end

        n_win  = r_win;
        n_cnt  = r_cnt;
        o_pop  = 1'b0;
        emit   = 1'b0;
        e_byte = r_win[WIN_W-1 -: 8];
        e_last = 1'b0;

        if (r_cnt >= CNT_W'(8)) begin
            // Drain the remaining bytes of a long code.
            if (out_free) begin
                emit   = 1'b1;
                n_win  = r_win << 8;
                n_cnt  = r_cnt - CNT_W'(8);
                e_last = n_cnt < CNT_W'(8);
            end
        end else if (!i_q_status.empty) begin
            if (m_cnt < CNT_W'(8)) begin
                o_pop = 1'b1;
                n_win = m_win;
                n_cnt = m_cnt;
            end else if (out_free) begin
                o_pop  = 1'b1;
                emit   = 1'b1;
                e_byte = m_win[WIN_W-1 -: 8];
                n_win  = m_win << 8;
                n_cnt  = m_cnt - CNT_W'(8);
                e_last = n_cnt < CNT_W'(8);
            end
        end

        o_out.valid    = r_ov;
        o_out.out_byte = r_ob;
        o_out.last     = r_ol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_win <= n_win;
            r_cnt <= n_cnt;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob <= e_byte;
            r_ol <= e_last;
        end
    end

    a_win_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win & ({WIN_W{1'b1}} >> r_cnt)) == '0)
        else $error("stray bits below the pending count");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.flush) |=> (r_cnt == '0 && r_ov && r_ol))
        else $error("flush did not emit a final byte and clear the window");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for huffman_code_bit_packer: directed and random table loads, encodes and flushes,
// with every packed byte checked against a bit-level predictor. Depends on hcbp_pkg, hcbp_if.
module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int IDLE_PCT     = 17;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 180;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_packed_byte;

    class bit_packer_model;
        logic [hcbp_pkg::CODE_W-1:0] code_word [256];
        logic [hcbp_pkg::LEN_W-1:0]  code_len [256];
        logic [6:0]        carry_bits;
        logic [2:0]        carry_count;
        t_packed_byte      expected_bytes [$];
        int                errors;

        function new();
            foreach (code_len[i]) begin
                code_word[i] = '0;
                code_len[i]  = '0;
            end
            carry_bits  = '0;
            carry_count = '0;
            errors      = 0;
        endfunction

        function void accept_request(logic [1:0] req, logic [7:0] sym, logic [31:0] bits,
                                     logic [5:0] len);
            logic [63:0]  acc;
            int           l;
            int           total;
            int           n;
            t_packed_byte b;
            case (req)
                hcbp_pkg::REQ_LOAD: begin
                    l = (int'(len) > hcbp_pkg::CODE_LIMIT) ? hcbp_pkg::CODE_LIMIT : int'(len);
                    acc = {32'b0, bits};
                    if (l < 32) acc = acc & ((64'd1 << l) - 64'd1);
                    code_word[sym] = acc[31:0];
                    code_len[sym]  = hcbp_pkg::LEN_W'(l);
                end
                hcbp_pkg::REQ_ENCODE: begin
                    l = int'(code_len[sym]);
                    acc = ({57'b0, carry_bits} << l) | {32'b0, code_word[sym]};
                    total = int'(carry_count) + l;
                    n = 0;
                    while (total >= 8 && n < 4) begin
                        b.data = 8'(acc >> (total - 8));
                        b.last = (total - 8 < 8) || (n == 3);
                        expected_bytes.push_back(b);
                        n++;
                        total -= 8;
                    end
                    carry_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                    carry_count = 3'(total);
                end
                hcbp_pkg::REQ_FLUSH: begin
                    // append the terminator, then pad with zeros up to the byte boundary
                    acc = ({57'b0, carry_bits} << 1) | 64'd1;
                    total = int'(carry_count) + 1;
                    b.data = 8'(acc << (8 - total));
                    b.last = 1'b1;
                    expected_bytes.push_back(b);
                    carry_bits  = '0;
                    carry_count = '0;
                end
                default: ;
            endcase
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_packed_byte exp_b;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual data %02h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (data !== exp_b.data) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, exp_b.data, data);
                errors++;
            end
            if (last !== exp_b.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, exp_b.last, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic steady;
    int   stall_cycles;

    hcbp_in_if  in_if ();
    hcbp_out_if out_if ();

    bit_packer_model packer = new();

    huffman_code_bit_packer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: stall at random unless in the steady stretch.
    always @(negedge i_clk) begin
        out_if.ready = i_rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            packer.check_byte(out_if.out_byte, out_if.last);
        if (!i_rst_n || (out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Enter and leave at a falling edge; hold the request until the transfer.
    task automatic send_request(input logic [1:0] req, input logic [7:0] sym,
                                input logic [31:0] bits, input logic [5:0] len);
        logic done;
        done = 1'b0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid       = 1'b1;
        in_if.req_type    = req;
        in_if.symbol      = sym;
        in_if.code_bits   = bits;
        in_if.code_length = len;
        while (!done) begin
            @(posedge i_clk);
            done = in_if.ready;
        end
        packer.accept_request(req, sym, bits, len);
        @(negedge i_clk);
    endtask

    task automatic drain_bytes();
        in_if.valid = 1'b0;
        while (packer.expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0]  req;
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;
        int          pick;

        i_rst_n            = 1'b0;
        steady             = 1'b0;
        stall_cycles       = 0;
        in_if.valid        = 1'b0;
        in_if.req_type     = hcbp_pkg::REQ_LOAD;
        in_if.symbol       = '0;
        in_if.code_bits    = '0;
        in_if.code_length  = '0;
        out_if.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty flush, absent codes, extremes and boundary fills
        send_request(hcbp_pkg::REQ_FLUSH,  8'h00, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(REQ_UNUSED,           8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_request(hcbp_pkg::REQ_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_request(hcbp_pkg::REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd63);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd1);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h02, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'h03, 32'hAAAA_AAAA, 6'd6);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_FLUSH,  8'h00, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h03, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_FLUSH,  8'h00, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'h55, 32'h5555_5555, 6'd32);
        send_request(hcbp_pkg::REQ_ENCODE, 8'h55, 32'h0, 6'd0);
        send_request(hcbp_pkg::REQ_LOAD,   8'hAA, 32'hAAAA_AAAA, 6'd31);
        send_request(hcbp_pkg::REQ_ENCODE, 8'hAA, 32'h0, 6'd0);
        drain_bytes();

        // random: mostly encodes over a small symbol pool so loaded codes get hit
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 60 && i < 120);
            if (i == 90 || i == 150) drain_bytes();
            pick = $urandom_range(0, 99);
            sym  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            bits = $urandom;
            len  = '0;
            if (pick < 15) begin
                req = hcbp_pkg::REQ_LOAD;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = 6'($urandom_range(0, 10));
                else if (pick < 92)
                    len = 6'($urandom_range(11, 32));
                else
                    len = 6'($urandom_range(33, 63));
            end else if (pick < 85) begin
                req = hcbp_pkg::REQ_ENCODE;
            end else if (pick < 95) begin
                req = hcbp_pkg::REQ_FLUSH;
            end else if (pick < 98) begin
                req = hcbp_pkg::REQ_ENCODE;
                sym = 8'($urandom);
            end else begin
                req = REQ_UNUSED;
                len = 6'($urandom);
            end
            send_request(req, sym, bits, len);
        end
        steady = 1'b0;
        drain_bytes();

        if (packer.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/hcbp_pkg.sv
hdl/hcbp_if.sv
hdl/hcbp_front.sv
hdl/hcbp_queue.sv
hdl/hcbp_back.sv
hdl/huffman_code_bit_packer.sv
bench/tb.sv
